// File: rtl/lge_pkg.sv
// shared types and constants for the life generation engine
// grid geometry, command codes, register indexes, payload and memory port structs
// no dependencies
package lge_pkg;

  // grid geometry
  localparam int GRID_COLUMNS   = 64;
  localparam int GRID_ROW_COUNT = 32;
  localparam int COL_W          = $clog2(GRID_COLUMNS);
  localparam int ROW_W          = $clog2(GRID_ROW_COUNT);
  // one memory word holds one grid row, bank bit on top of the row index
  localparam int ADDR_W         = ROW_W + 1;
  localparam int CFG_DATA_W     = 7;
  localparam int CFG_INDEX_W    = 2;

  // command codes
  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_ADVANCE = 2'd2
  } cmd_t;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS    = 2'd1;

  // reset values of the size registers
  localparam logic [6:0] COLUMNS_RESET = 7'd50;
  localparam logic [5:0] ROWS_RESET    = 6'd30;

  typedef logic [GRID_COLUMNS-1:0] row_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [COL_W-1:0] cell_column;
    logic [ROW_W-1:0] cell_row;
    logic             cell_value;
  } in_data_t;

  typedef struct packed {
    logic read_value;
    logic out_of_range;
  } out_data_t;

  // request into the row memory
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    row_t              wr_data;
  } mem_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_ADV,
    ST_RESULT
  } state_t;

endpackage

// File: rtl/life_generation_engine.sv
// life generation engine top level: command sequencer, size registers, output register
// sequence: out-of-range and unused commands go IDLE then RESULT, in-range read/write IDLE, CELL, RESULT,
//   advance IDLE, ADV, RESULT (one grid row per cycle through the single memory read port)
// one command at a time: in_stall holds off a new command until the sequencer is back in IDLE
// reset: grid reads all dead via per-row valid bits (no clearing pass), 50 columns,
//   30 rows, bank 0, no result pending
// depends on lge_pkg, lge_row_mem, lge_row_rule
module life_generation_engine
  import lge_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // command channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_data_t               in_data,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_data_t              out_data,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_W = ROW_W + 1;
  localparam logic [CNT_W-1:0] LAST_READ = CNT_W'(GRID_ROW_COUNT);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(GRID_ROW_COUNT + 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             bank_r, bank_nxt;
  logic [6:0]       cols_r;
  logic [5:0]       rows_r;
  logic             op_write_r, op_write_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             val_r, val_nxt;
  out_data_t        res_r, res_nxt;
  row_t             above_r, above_nxt;
  row_t             cur_r, cur_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_data_t        out_data_r, out_data_nxt;

  mem_req_t         req;
  row_t             rd_row;
  row_t             below;
  row_t             next_row;
  row_t             col_mask;
  row_t             cell_bit;
  logic [6:0]       used_cols;
  logic [5:0]       used_rows;
  logic             in_range;
  logic             in_xfer;
  logic [CNT_W-1:0] in_row_idx;
  logic [CNT_W-1:0] out_row_idx;

  lge_row_mem u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .rd_row (rd_row)
  );

  lge_row_rule u_rule (
    .above    (above_r),
    .center   (cur_r),
    .below    (below),
    .next_row (next_row)
  );

  // size registers clamp to the grid
  assign used_cols = (cols_r > 7'(GRID_COLUMNS)) ? 7'(GRID_COLUMNS) : cols_r;
  assign used_rows = (rows_r > 6'(GRID_ROW_COUNT)) ? 6'(GRID_ROW_COUNT) : rows_r;

  always_comb begin
    for (int c = 0; c < GRID_COLUMNS; c++) begin
      col_mask[c] = (7'(c) < used_cols);
    end
  end

  assign in_range = ({1'b0, in_data.cell_column} < used_cols)
                 && ({1'b0, in_data.cell_row} < used_rows);

  // rows arriving from memory and the row being written during an advance
  assign in_row_idx  = cnt_r - CNT_W'(1);
  assign out_row_idx = cnt_r - CNT_W'(2);
  assign below = ((cnt_r != '0) && (cnt_r <= LAST_READ) && (in_row_idx < used_rows))
               ? (rd_row & col_mask) : '0;

  assign cell_bit = row_t'(1) << col_r;

  // configuration transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLUMNS_RESET;
      rows_r <= ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COLUMNS: cols_r <= cfg_data;
        CFG_ROWS:    rows_r <= cfg_data[5:0];
        default:     ;
      endcase
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // sequencer next state and memory requests
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    bank_nxt      = bank_r;
    op_write_nxt  = op_write_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    val_nxt       = val_r;
    res_nxt       = res_r;
    above_nxt     = above_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    req           = '0;

    // output register drains on a transfer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          op_write_nxt = (in_data.command == CMD_WRITE);
          col_nxt      = in_data.cell_column;
          row_nxt      = in_data.cell_row;
          val_nxt      = in_data.cell_value;
          res_nxt      = '0;
          priority if (in_data.command == CMD_WRITE || in_data.command == CMD_READ) begin
            if (in_range) begin
              req.rd_en   = 1'b1;
              req.rd_addr = {bank_r, in_data.cell_row};
              state_nxt   = ST_CELL;
            end else begin
              res_nxt.out_of_range = 1'b1;
              state_nxt            = ST_RESULT;
            end
          end else if (in_data.command == CMD_ADVANCE) begin
            cnt_nxt   = '0;
            above_nxt = '0;
            cur_nxt   = '0;
            state_nxt = ST_ADV;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end

      ST_CELL: begin
        // read-modify-write of the addressed row on a write, bit select on a read
        if (op_write_r) begin
          req.wr_en   = 1'b1;
          req.wr_addr = {bank_r, row_r};
          req.wr_data = val_r ? (rd_row | cell_bit) : (rd_row & ~cell_bit);
        end else begin
          res_nxt.read_value = rd_row[col_r];
        end
        state_nxt = ST_RESULT;
      end

      ST_ADV: begin
        // read rows of the live bank in order
        if (cnt_r < LAST_READ) begin
          req.rd_en   = 1'b1;
          req.rd_addr = {bank_r, cnt_r[ROW_W-1:0]};
        end
        // write the new row (index cnt_r - 2) into the other bank
        if (cnt_r >= CNT_W'(2)) begin
          req.wr_en   = 1'b1;
          req.wr_addr = {~bank_r, out_row_idx[ROW_W-1:0]};
          req.wr_data = (out_row_idx < used_rows) ? (next_row & col_mask) : '0;
        end
        above_nxt = cur_r;
        cur_nxt   = below;
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_STEP) begin
          bank_nxt  = ~bank_r;
          state_nxt = ST_RESULT;
        end
      end

      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // payload and row window registers
  always_ff @(posedge clk) begin
    op_write_r <= op_write_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    val_r      <= val_nxt;
    res_r      <= res_nxt;
    above_r    <= above_nxt;
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/lge_row_mem.sv
// row memory for both grid banks, one row per word, one read and one write port
// per-row valid bits make unwritten rows read as dead after reset
// depends on lge_pkg
module lge_row_mem
  import lge_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output row_t     rd_row
);

  localparam int DEPTH = 2 ** ADDR_W;

  row_t             mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  row_t             rd_data_r;
  logic             rd_valid_r;

  // storage write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_addr];
      end
    end
  end

  // a row never written reads as all dead
  assign rd_row = rd_valid_r ? rd_data_r : '0;

endmodule

// File: rtl/lge_row_rule.sv
// b3/s23 rule applied to one whole row, one lane per column
// depends on lge_pkg
module lge_row_rule
  import lge_pkg::*;
(
  input  row_t above,
  input  row_t center,
  input  row_t below,
  output row_t next_row
);

  // dead border on both sides
  logic [GRID_COLUMNS+1:0] a_ext;
  logic [GRID_COLUMNS+1:0] c_ext;
  logic [GRID_COLUMNS+1:0] b_ext;

  assign a_ext = {1'b0, above, 1'b0};
  assign c_ext = {1'b0, center, 1'b0};
  assign b_ext = {1'b0, below, 1'b0};

  for (genvar c = 0; c < GRID_COLUMNS; c++) begin : g_lane
    logic [3:0] count;

    // eight neighbors of this lane
    assign count = {3'b0, a_ext[c]} + {3'b0, a_ext[c+1]} + {3'b0, a_ext[c+2]}
                 + {3'b0, c_ext[c]} + {3'b0, c_ext[c+2]}
                 + {3'b0, b_ext[c]} + {3'b0, b_ext[c+1]} + {3'b0, b_ext[c+2]};

    // born with three, survives with two or three
    assign next_row[c] = (count == 4'd3) || (center[c] && (count == 4'd2));
  end

endmodule
